// ----- sv/ate_pkg.sv -----
// shared types, constants and table builders for the turbulence energy block
`timescale 1ns / 1ps
package ate_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DIR_BITS   = 16;
   localparam int LG_FRAC    = 16;
   localparam int H_W        = 36;
   localparam int IDX_W      = 6;
   localparam int LG_W       = IDX_W + LG_FRAC;
   localparam int Y_W        = 31;
   localparam int SQ_STAGES  = 16;
   localparam int MSQ_W      = 64;
   localparam int T_W        = 13;
   localparam int S_W        = 27;
   localparam int PROD_W     = S_W + MSQ_W;
   localparam int T_BASE     = 30 + FRAC_BITS;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam logic [17:0] EXP_OFFSET = 18'd3277;
   localparam logic [26:0] K_SCALE    = 27'd64424509;
   localparam logic [30:0] OUT_MAX    = 31'h7FFF_FFFF;
   localparam logic [Y_W-1:0] P_ONE   = Y_W'(1) << 30;

   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 2'd3;

   typedef struct packed {
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic signed [31:0] ground_height;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] face_flux;
   } req_item_type;

   typedef struct packed {
      logic [30:0] energy_value;
      logic        inflow_flag;
   } rsp_item_type;

   // data that rides along with an item through the long stages
   typedef struct packed {
      logic [MSQ_W-1:0] msq;
      logic             inflow;
   } side_type;

   typedef logic [15:0][Y_W-1:0] pow_tab_type;
   typedef logic [3:0][LG_W-1:0] lg_tab_type;

   function automatic logic [1:0] a_class(input logic [16:0] a);
      logic [1:0] c;
      if (a <= 17'd6554)       c = 2'd0;
      else if (a <= 17'd9175)  c = 2'd1;
      else if (a <= 17'd14418) c = 2'd2;
      else                     c = 2'd3;
      return c;
   endfunction

   function automatic logic [H_W-1:0] zb_of(input logic [1:0] c);
      logic [H_W-1:0] z;
      case (c)
         2'd0:    z = H_W'(5) << FRAC_BITS;
         2'd1:    z = H_W'(5) << FRAC_BITS;
         2'd2:    z = H_W'(10) << FRAC_BITS;
         default: z = H_W'(30) << FRAC_BITS;
      endcase
      return z;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [LG_W-1:0] lg_q16(input logic [63:0] v);
      logic [63:0] y;
      int          n;
      logic [15:0] fr;
      n = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = i;
      end
      y = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
      fr = '0;
      for (int i = 0; i < 16; i++) begin
         y = (y * y) >> 30;
         fr = {fr[14:0], 1'b0};
         if (y >= 64'h8000_0000) begin
            y = y >> 1;
            fr[0] = 1'b1;
         end
      end
      return {IDX_W'(n), fr};
   endfunction

   function automatic pow_tab_type pow_table();
      pow_tab_type t;
      logic [63:0] c;
      c = isqrt64(64'h2000_0000_0000_0000);
      for (int j = 15; j >= 0; j--) begin
         t[j] = c[Y_W-1:0];
         c = isqrt64(c << 30);
      end
      return t;
   endfunction

   function automatic lg_tab_type lg_zg_table();
      lg_tab_type t;
      t[0] = lg_q16(64'(250) << FRAC_BITS);
      t[1] = lg_q16(64'(350) << FRAC_BITS);
      t[2] = lg_q16(64'(450) << FRAC_BITS);
      t[3] = lg_q16(64'(650) << FRAC_BITS);
      return t;
   endfunction

   localparam pow_tab_type POW_C = pow_table();
   localparam lg_tab_type  LG_ZG = lg_zg_table();

endpackage

// ----- sv/ate_front.sv -----
// front stages: height above ground with clamp, and speed squared
`timescale 1ns / 1ps
module ate_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  ate_pkg::req_item_type     in_item,
   input  logic signed [17:0]        dir_x,
   input  logic signed [17:0]        dir_y,
   input  logic signed [17:0]        dir_z,
   input  logic [ate_pkg::H_W-1:0]   zb_h,
   output logic                      out_valid,
   output logic [ate_pkg::H_W-1:0]   h_out,
   output ate_pkg::side_type         side_out
);
   import ate_pkg::*;

   logic signed [31:0] cx, cy, cz;
   logic [31:0]        ax, ay, az;
   logic signed [49:0] px_in, py_in, pz_in;
   logic [MSQ_W-1:0]   mx_in, my_in, mz_in;

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [49:0] px_ff, py_ff, pz_ff;
   logic [MSQ_W-1:0]   mx_ff, my_ff, mz_ff;
   logic signed [31:0] gnd1_ff, gnd2_ff;
   logic               infl1_ff, infl2_ff;

   logic signed [51:0] dot_in, dot_ff;
   logic [MSQ_W-1:0]   msq_in, msq_ff;

   logic signed [35:0] elev;
   logic signed [36:0] hd;
   logic signed [36:0] zbs;
   logic [H_W-1:0]     h_in, h_ff;
   side_type           side_ff;

   assign cx = in_item.centre_x;
   assign cy = in_item.centre_y;
   assign cz = in_item.centre_z;
   assign ax = in_item.vel_x[31] ? (~in_item.vel_x + 32'd1) : in_item.vel_x;
   assign ay = in_item.vel_y[31] ? (~in_item.vel_y + 32'd1) : in_item.vel_y;
   assign az = in_item.vel_z[31] ? (~in_item.vel_z + 32'd1) : in_item.vel_z;

   assign px_in = cx * dir_x;
   assign py_in = cy * dir_y;
   assign pz_in = cz * dir_z;
   assign mx_in = ax * ax;
   assign my_in = ay * ay;
   assign mz_in = az * az;

   assign dot_in = 52'(px_ff) + 52'(py_ff) + 52'(pz_ff);
   assign msq_in = mx_ff + my_ff + mz_ff;

   assign elev = 36'(dot_ff >>> DIR_BITS);
   assign hd   = 37'(elev) - 37'(gnd2_ff);
   assign zbs  = signed'({1'b0, zb_h});
   assign h_in = (hd <= zbs) ? zb_h : hd[H_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         mz_ff    <= mz_in;
         gnd1_ff  <= in_item.ground_height;
         infl1_ff <= in_item.face_flux[31];

         dot_ff   <= dot_in;
         msq_ff   <= msq_in;
         gnd2_ff  <= gnd1_ff;
         infl2_ff <= infl1_ff;

         h_ff           <= h_in;
         side_ff.msq    <= msq_ff;
         side_ff.inflow <= infl2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign h_out     = h_ff;
   assign side_out  = side_ff;

endmodule

// ----- sv/ate_log2.sv -----
// log2 pipeline: msb search, normalize, one squaring per stage
`timescale 1ns / 1ps
module ate_log2 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [ate_pkg::H_W-1:0]   h_in,
   input  ate_pkg::side_type         side_in,
   output logic                      out_valid,
   output logic [ate_pkg::LG_W-1:0]  lg_out,
   output ate_pkg::side_type         side_out
);
   import ate_pkg::*;

   logic [IDX_W-1:0]   idx_in;
   logic               va_ff;
   logic [H_W-1:0]     ha_ff;
   logic [IDX_W-1:0]   idxa_ff;
   side_type           sidea_ff;
   logic [H_W-1:0]     hn;

   logic               v_ff    [SQ_STAGES+1];
   logic [Y_W-1:0]     y_ff    [SQ_STAGES+1];
   logic [LG_FRAC-1:0] frac_ff [SQ_STAGES+1];
   logic [IDX_W-1:0]   idx_ff  [SQ_STAGES+1];
   side_type           side_ff [SQ_STAGES+1];

   always_comb begin
      idx_in = '0;
      for (int i = 0; i < H_W; i++) begin
         if (h_in[i]) idx_in = IDX_W'(i);
      end
   end

   // put the msb at the top, keep a Q1.30 mantissa
   assign hn = ha_ff << (IDX_W'(H_W - 1) - idxa_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         va_ff   <= in_valid;
         v_ff[0] <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ha_ff      <= h_in;
         idxa_ff    <= idx_in;
         sidea_ff   <= side_in;
         y_ff[0]    <= hn[H_W-1:H_W-Y_W];
         frac_ff[0] <= '0;
         idx_ff[0]  <= idxa_ff;
         side_ff[0] <= sidea_ff;
      end
   end

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      logic [2*Y_W-1:0]   sq;
      logic [Y_W:0]       sqh;
      logic [Y_W-1:0]     y_in;
      logic [LG_FRAC-1:0] fr_in;

      assign sq  = y_ff[g] * y_ff[g];
      assign sqh = sq[2*Y_W-1:Y_W-1];
      assign y_in = sqh[Y_W] ? sqh[Y_W:1] : sqh[Y_W-1:0];

      always_comb begin
         fr_in = frac_ff[g];
         fr_in[LG_FRAC-1-g] = sqh[Y_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (adv) begin
            v_ff[g+1] <= v_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            y_ff[g+1]    <= y_in;
            frac_ff[g+1] <= fr_in;
            idx_ff[g+1]  <= idx_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = v_ff[SQ_STAGES];
   assign lg_out    = {idx_ff[SQ_STAGES], frac_ff[SQ_STAGES]};
   assign side_out  = side_ff[SQ_STAGES];

endmodule

// ----- sv/ate_pow2.sv -----
// fractional power of two: one conditional constant multiply per stage
`timescale 1ns / 1ps
module ate_pow2 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic [15:0]                     f_in,
   input  logic signed [ate_pkg::T_W-1:0]  t_in,
   input  ate_pkg::side_type               side_in,
   output logic                            out_valid,
   output logic [ate_pkg::Y_W-1:0]         p_out,
   output logic signed [ate_pkg::T_W-1:0]  t_out,
   output ate_pkg::side_type               side_out
);
   import ate_pkg::*;

   logic                  v_ff    [16];
   logic [Y_W-1:0]        p_ff    [16];
   logic [15:0]           f_ff    [16];
   logic signed [T_W-1:0] t_ff    [16];
   side_type              side_ff [16];

   for (genvar g = 0; g < 16; g++) begin : g_pw
      localparam int J = 15 - g;
      logic                  v_cur;
      logic [Y_W-1:0]        p_cur;
      logic [15:0]           f_cur;
      logic signed [T_W-1:0] t_cur;
      side_type              s_cur;
      logic [2*Y_W-1:0]      prod;
      logic [Y_W-1:0]        p_in;

      if (g == 0) begin : g_first
         assign v_cur = in_valid;
         assign p_cur = P_ONE;
         assign f_cur = f_in;
         assign t_cur = t_in;
         assign s_cur = side_in;
      end else begin : g_next
         assign v_cur = v_ff[g-1];
         assign p_cur = p_ff[g-1];
         assign f_cur = f_ff[g-1];
         assign t_cur = t_ff[g-1];
         assign s_cur = side_ff[g-1];
      end

      assign prod = p_cur * POW_C[J];
      assign p_in = f_cur[J] ? prod[2*Y_W-2:Y_W-1] : p_cur;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (adv) begin
            v_ff[g] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            p_ff[g]    <= p_in;
            f_ff[g]    <= f_cur;
            t_ff[g]    <= t_cur;
            side_ff[g] <= s_cur;
         end
      end
   end

   assign out_valid = v_ff[15];
   assign p_out     = p_ff[15];
   assign t_out     = t_ff[15];
   assign side_out  = side_ff[15];

endmodule

// ----- sv/atm_inlet_turbulence_energy_core.sv -----
// top level: turbulence energy at an inlet face, fully pipelined
`timescale 1ns / 1ps
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  request  | req_valid req_ready req_item   | one face item in
//  response | rsp_valid rsp_ready rsp_item   | one energy/inflow item out
//  csr      | csr_wr_en csr_index csr_wdata  | direction and exponent writes
//
//  one item enters per cycle while req_ready is high; an item passes 45 register
//  stages on its way to rsp_valid; most of the depth is the 16 squaring
//  stages of the log2 unit and the 16 constant multiply stages of the power unit
//  reset (synchronous, active high) clears valid bits and loads register defaults
//  a stall on rsp_ready freezes the whole pipe; req_ready drops only while the
//  output register holds an item that is not taken
//
module atm_inlet_turbulence_energy_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ate_pkg::req_item_type              req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ate_pkg::rsp_item_type              rsp_item,
   input  logic                               csr_wr_en,
   input  logic [ate_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ate_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ate_pkg::*;

   // configuration registers
   logic signed [17:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic [16:0]        exp_ff;

   logic [1:0]  cls;
   logic [17:0] e_val;
   logic signed [18:0] e_s;

   // global advance: the pipe moves when the output slot is free or drained
   logic adv;

   logic             fr_valid;
   logic [H_W-1:0]   fr_h;
   side_type         fr_side;
   logic             lg_valid;
   logic [LG_W-1:0]  lg_val;
   side_type         lg_side;

   // log difference, exponent product, split into integer and fraction
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [22:0] l_in, l_ff;
   side_type           s1_ff, s2_ff, s3_ff;
   logic signed [41:0] el_in, el_ff;
   logic signed [42:0] nel;
   logic signed [26:0] xq;
   logic signed [10:0] n_val;
   logic signed [T_W-1:0] t_in, t3_ff;
   logic [15:0]        f3_ff;

   logic                  pw_valid;
   logic [Y_W-1:0]        pw_p;
   logic signed [T_W-1:0] pw_t;
   side_type              pw_side;

   // energy scaling and final shift
   logic                  v4_ff, v5_ff, v6_ff, v7_ff;
   logic [2*Y_W-1:0]      pp;
   logic [31:0]           q_ff;
   logic [58:0]           qk;
   logic [S_W-1:0]        s_ff;
   logic [58:0]           plo_in, phi_in, plo_ff, phi_ff;
   logic [PROD_W-1:0]     prod_in, prod_ff;
   logic signed [T_W-1:0] t4_ff, t5_ff, t6_ff, t7_ff;
   side_type              s4_ff, s5_ff, s6_ff;
   logic                  infl7_ff;
   logic [PROD_W-1:0]     sh;
   logic [30:0]           energy_in;

   logic                  rsp_valid_ff;
   rsp_item_type          rsp_item_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= 18'sd65536;
         exp_ff   <= 17'd14418;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIR_X:    dir_x_ff <= csr_wdata;
            CSR_DIR_Y:    dir_y_ff <= csr_wdata;
            CSR_DIR_Z:    dir_z_ff <= csr_wdata;
            CSR_EXPONENT: exp_ff   <= csr_wdata[16:0];
            default:      ;
         endcase
      end
   end

   // cls picks ref heights; user keeps exp static while items in flight, unenforced
   assign cls   = a_class(exp_ff);
   assign e_val = {1'b0, exp_ff} + EXP_OFFSET;
   assign e_s   = signed'({1'b0, e_val});

   ate_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .dir_x     (dir_x_ff),
      .dir_y     (dir_y_ff),
      .dir_z     (dir_z_ff),
      .zb_h      (zb_of(cls)),
      .out_valid (fr_valid),
      .h_out     (fr_h),
      .side_out  (fr_side)
   );

   ate_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .h_in      (fr_h),
      .side_in   (fr_side),
      .out_valid (lg_valid),
      .lg_out    (lg_val),
      .side_out  (lg_side)
   );

   // log of height relative to the class reference height
   assign l_in  = signed'({1'b0, lg_val}) - signed'({1'b0, LG_ZG[cls]});
   assign el_in = e_s * l_ff;
   // floor shifts on the negated product
   assign nel   = -43'(el_ff);
   assign xq    = 27'(nel >>> 16);
   assign n_val = 11'(xq >>> 16);
   assign t_in  = T_W'(T_BASE) - (T_W'(n_val) <<< 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= lg_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l_ff  <= l_in;
         s1_ff <= lg_side;
         el_ff <= el_in;
         s2_ff <= s1_ff;
         f3_ff <= xq[15:0];
         t3_ff <= t_in;
         s3_ff <= s2_ff;
      end
   end

   ate_pow2 u_pow2 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .f_in      (f3_ff),
      .t_in      (t3_ff),
      .side_in   (s3_ff),
      .out_valid (pw_valid),
      .p_out     (pw_p),
      .t_out     (pw_t),
      .side_out  (pw_side)
   );

   // intensity squared times 0.015, then times speed squared in two halves
   assign pp      = pw_p * pw_p;
   assign qk      = q_ff * K_SCALE;
   assign plo_in  = s_ff * s5_ff.msq[31:0];
   assign phi_in  = s_ff * s5_ff.msq[63:32];
   assign prod_in = (PROD_W'(phi_ff) << 32) + PROD_W'(plo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= pw_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff     <= pp[2*Y_W-1:30];
         t4_ff    <= pw_t;
         s4_ff    <= pw_side;
         s_ff     <= qk[58:32];
         t5_ff    <= t4_ff;
         s5_ff    <= s4_ff;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         t6_ff    <= t5_ff;
         s6_ff    <= s5_ff;
         prod_ff  <= prod_in;
         t7_ff    <= t6_ff;
         infl7_ff <= s6_ff.inflow;
      end
   end

   // scale by 2^-t with saturation; negative t saturates any nonzero product
   assign sh = prod_ff >> t7_ff[T_W-2:0];

   always_comb begin
      if (t7_ff < 0) begin
         energy_in = (prod_ff != '0) ? OUT_MAX : '0;
      end else if (sh[PROD_W-1:31] != '0) begin
         energy_in = OUT_MAX;
      end else begin
         energy_in = sh[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_item_ff.energy_value <= energy_in;
         rsp_item_ff.inflow_flag  <= infl7_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- sim/atm_inlet_turbulence_energy_core_test.sv -----
// testbench for the inlet turbulence energy block: directed and random faces checked against a local predictor
`timescale 1ns / 1ps
module atm_inlet_turbulence_energy_core_test;
   import ate_pkg::*;

   // scoreboard: computes expected energy items and keeps them in order
   class energy_board;
      logic signed [17:0] dx, dy, dz;
      logic [16:0]        expo;
      rsp_item_type       pending[$];
      int                 errors;
      int                 checked;

      function void set_defaults();
         dx = 18'sd0;
         dy = 18'sd0;
         dz = 18'sd65536;
         expo = 17'd14418;
      endfunction

      // integer square root, bit by bit
      function logic [63:0] root(input logic [63:0] v_in);
         logic [63:0] v, r, b;
         v = v_in;
         r = '0;
         b = 64'h4000_0000_0000_0000;
         while (b > v && b != 0) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // log2 in q.16
      function longint log2_fix(input logic [63:0] v);
         int          msb;
         logic [63:0] y;
         longint      fr;
         msb = 0;
         fr = 0;
         if (v == 0) return 0;
         for (int i = 0; i < 64; i++) if (v[i]) msb = i;
         y = (msb >= 30) ? (v >> (msb - 30)) : (v << (30 - msb));
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            fr = fr << 1;
            if (y >= 64'h8000_0000) begin
               y = y >> 1;
               fr = fr | 1;
            end
         end
         return (longint'(msb) << 16) + fr;
      endfunction

      function longint floor_div(input longint v, input int s);
         return v >>> s;
      endfunction

      function rsp_item_type predict(input req_item_type it);
         rsp_item_type r;
         longint       zg, zb, dot, ht, lgl, ex, xq, n, t;
         logic [63:0]  p, c, q, s, msq, mx, my, mz;
         logic [127:0] prod, sh;
         logic [15:0]  f;
         if (expo <= 17'd6554) begin zg = 250; zb = 5; end
         else if (expo <= 17'd9175) begin zg = 350; zb = 5; end
         else if (expo <= 17'd14418) begin zg = 450; zb = 10; end
         else begin zg = 650; zb = 30; end
         dot = longint'(it.centre_x) * dx + longint'(it.centre_y) * dy
               + longint'(it.centre_z) * dz;
         ht = floor_div(dot, 16) - longint'(it.ground_height);
         if (ht <= (zb << 16)) ht = zb << 16;
         lgl = log2_fix(ht) - log2_fix(zg << 16);
         ex = longint'(expo) + 3277;
         xq = floor_div(-(ex * lgl), 16);
         n = floor_div(xq, 16);
         f = xq[15:0];
         p = 64'd1 << 30;
         c = root(64'd1 << 61);
         for (int j = 15; j >= 0; j--) begin
            if (f[j]) p = (p * c) >> 30;
            c = root(c << 30);
         end
         q = (p * p) >> 30;
         s = (q * 64'd64424509) >> 32;
         mx = it.vel_x < 0 ? -longint'(it.vel_x) : longint'(it.vel_x);
         my = it.vel_y < 0 ? -longint'(it.vel_y) : longint'(it.vel_y);
         mz = it.vel_z < 0 ? -longint'(it.vel_z) : longint'(it.vel_z);
         msq = mx * mx + my * my + mz * mz;
         prod = 128'(s) * 128'(msq);
         t = 46 - 2 * n;
         if (t < 0) sh = (prod != 0) ? 128'(OUT_MAX) : 128'd0;
         else if (t >= 128) sh = 0;
         else begin
            sh = prod >> t;
            if ((prod >> t) > 128'(OUT_MAX)) sh = 128'(OUT_MAX);
         end
         r.energy_value = (sh > 128'(OUT_MAX)) ? OUT_MAX : sh[30:0];
         r.inflow_flag = it.face_flux[31];
         return r;
      endfunction

      function void note_face(input req_item_type it);
         pending.push_back(predict(it));
      endfunction

      function void check_result(input rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item energy=%0d inflow=%0b", $time,
                     got.energy_value, got.inflow_flag);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.energy_value !== want.energy_value) begin
            $display("%0t: energy_value expected %0d actual %0d", $time,
                     want.energy_value, got.energy_value);
            errors++;
         end
         if (got.inflow_flag !== want.inflow_flag) begin
            $display("%0t: inflow_flag expected %0b actual %0b", $time,
                     want.inflow_flag, got.inflow_flag);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   req_item_type                 req_item;
   logic                         rsp_valid;
   logic                         rsp_ready;
   rsp_item_type                 rsp_item;
   logic                         csr_wr_en;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;

   energy_board board;
   bit          calm;        // no idling in the last part of the run
   int          sent;
   int          quiet_cycles;
   bit          timed_out;

   localparam int QUIET_LIMIT = 4000;

   atm_inlet_turbulence_energy_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // scoreboard sampling at each edge: accepted faces predicted, results checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_face(req_item);
         if (rsp_valid && rsp_ready) board.check_result(rsp_item);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
         $display("atm_inlet_turbulence_energy_core_test failed");
         $finish;
      end
   end

   // receiver: stalls in random bursts until the calm phase
   initial begin : receiver
      int hold;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            hold = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [17:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DIR_X:    board.dx = val;
         CSR_DIR_Y:    board.dy = val;
         CSR_DIR_Z:    board.dz = val;
         CSR_EXPONENT: board.expo = val[16:0];
         default: ;
      endcase
   endtask

   // only between phases: drain and let the pipe empty out
   task automatic settle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic send_face(input req_item_type it);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   function automatic logic [31:0] edgy32();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // a face whose height lands in a sensible range, most of the time
   function automatic req_item_type random_face();
      req_item_type it;
      if ($urandom_range(0, 3) == 0) begin
         it = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
         it.ground_height = edgy32();
         it.vel_x = edgy32();
      end else begin
         it.centre_x = $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF;
         it.centre_y = $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sh1FFFFFF;
         it.centre_z = $urandom_range(0, 2000 << 16);
         it.ground_height = $signed($urandom_range(0, 100 << 16)) - 32'sh320000;
         it.vel_x = $signed($urandom_range(0, 60 << 16)) - 32'sh1E0000;
         it.vel_y = $signed($urandom_range(0, 60 << 16)) - 32'sh1E0000;
         it.vel_z = $signed($urandom_range(0, 10 << 16)) - 32'sh50000;
         it.face_flux = $urandom;
      end
      return it;
   endfunction

   function automatic logic [17:0] random_dir();
      case ($urandom_range(0, 5))
         0: return 18'h10000;
         1: return 18'h30000;
         2: return 18'h00000;
         3: return 18'h3FFFF;
         4: return 18'h1FFFF;
         default: return 18'($urandom_range(0, 18'h3FFFF));
      endcase
   endfunction

   initial begin : stimulus
      req_item_type it;
      logic [16:0]  expo_set[8] = '{17'd0, 17'd6554, 17'd6555, 17'd9175,
                                    17'd14418, 17'd14419, 17'd65536, 17'h1FFFF};
      board = new();
      board.set_defaults();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_DIR_X;
      csr_wdata <= '0;
      calm = 1'b0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed faces at reset settings: ground clamp, zero speed, extremes, flux sign
      it = '0;
      send_face(it);
      it.face_flux = 32'h8000_0000;
      it.vel_x = 32'h8000_0000;
      it.vel_y = 32'h8000_0000;
      it.vel_z = 32'h8000_0000;
      send_face(it);
      it = '0;
      it.centre_z = 32'h7FFF_FFFF;
      it.ground_height = 32'h8000_0000;
      it.vel_x = 32'h7FFF_FFFF;
      it.face_flux = 32'h7FFF_FFFF;
      send_face(it);
      it.centre_z = 32'h0064_0000;
      it.ground_height = 32'h0;
      it.vel_x = 32'h000A_0000;
      it.face_flux = 32'hFFFF_FFFF;
      send_face(it);
      it.centre_z = 32'h8000_0000;
      it.ground_height = 32'h7FFF_FFFF;
      send_face(it);
      it.centre_z = 32'h000A_0000;
      it.vel_y = 32'h0000_0001;
      send_face(it);
      for (int i = 0; i < 6; i++) send_face(random_face());

      // phases: new direction and exponent, then random faces
      for (int ph = 0; ph < 13; ph++) begin
         req_valid <= 1'b0;
         settle();
         if (ph < 8) begin
            write_reg(CSR_EXPONENT, {1'b0, expo_set[ph]});
         end else begin
            write_reg(CSR_EXPONENT, 18'($urandom_range(0, 17'h1FFFF)));
         end
         if (ph == 0) begin
            write_reg(CSR_DIR_X, 18'h10000);
            write_reg(CSR_DIR_Y, 18'h30000);
            write_reg(CSR_DIR_Z, 18'h0);
         end else if (ph == 12) begin
            write_reg(CSR_DIR_X, 18'h0);
            write_reg(CSR_DIR_Y, 18'h0);
            write_reg(CSR_DIR_Z, 18'h10000);
         end else if (ph % 3 == 0) begin
            write_reg(CSR_DIR_X, random_dir());
            write_reg(CSR_DIR_Y, random_dir());
            write_reg(CSR_DIR_Z, random_dir());
         end
         if (ph == 11) calm = 1'b1;
         repeat (150) send_face(random_face());
      end
      req_valid <= 1'b0;

      // wait for the pipe to drain, then a little extra for strays
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("covered %0d faces over 13 register settings, %0d results checked",
               sent, board.checked);
      $display("exponent classes at their edges, clamped heights, saturated and zero energy");
      if (board.errors == 0)
         $display("atm_inlet_turbulence_energy_core_test passed");
      else
         $display("atm_inlet_turbulence_energy_core_test failed");
      $finish;
   end

endmodule

// ----- atm_inlet_turbulence_energy_core.f -----
sv/ate_pkg.sv
sv/ate_front.sv
sv/ate_log2.sv
sv/ate_pow2.sv
sv/atm_inlet_turbulence_energy_core.sv
sim/atm_inlet_turbulence_energy_core_test.sv
